### rtl/assert_macros.svh
// assertion macros shared by the decoder rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define MID_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// consequent that must hold in the cycle after the antecedent
`define MID_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/mid_pkg.sv
// types and constants of the messagepack integer decoder
`default_nettype none

package mid_pkg;

    localparam logic [2:0] MODE_S32  = 3'd0;
    localparam logic [2:0] MODE_U32  = 3'd1;
    localparam logic [2:0] MODE_S64  = 3'd2;
    localparam logic [2:0] MODE_U64  = 3'd3;
    localparam logic [2:0] MODE_BOOL = 3'd4;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_BAD_TAG = 2'd1;
    localparam logic [1:0] STATUS_RANGE   = 2'd2;

    localparam logic [7:0] TAG_POS_FIX_MAX = 8'h7f;
    localparam logic [7:0] TAG_NEG_FIX_MIN = 8'he0;
    localparam logic [7:0] TAG_FALSE       = 8'hc2;
    localparam logic [7:0] TAG_TRUE        = 8'hc3;
    localparam logic [7:0] TAG_UINT8       = 8'hcc;
    localparam logic [7:0] TAG_UINT16      = 8'hcd;
    localparam logic [7:0] TAG_UINT32      = 8'hce;
    localparam logic [7:0] TAG_UINT64      = 8'hcf;
    localparam logic [7:0] TAG_INT8        = 8'hd0;
    localparam logic [7:0] TAG_INT16       = 8'hd1;
    localparam logic [7:0] TAG_INT32       = 8'hd2;
    localparam logic [7:0] TAG_INT64       = 8'hd3;

    // kind: bit 2 signed, bits 1:0 log2 of payload bytes
    localparam logic [2:0] KIND_U8  = 3'd0;
    localparam logic [2:0] KIND_U16 = 3'd1;
    localparam logic [2:0] KIND_U32 = 3'd2;
    localparam logic [2:0] KIND_U64 = 3'd3;
    localparam logic [2:0] KIND_S8  = 3'd4;
    localparam logic [2:0] KIND_S16 = 3'd5;
    localparam logic [2:0] KIND_S32 = 3'd6;
    localparam logic [2:0] KIND_S64 = 3'd7;

    localparam logic [1:0] SIZE_1 = 2'd0;
    localparam logic [1:0] SIZE_2 = 2'd1;
    localparam logic [1:0] SIZE_4 = 2'd2;
    localparam logic [1:0] SIZE_8 = 2'd3;

    // work item from the parser to the range checker
    typedef struct packed {
        logic        is_finish;
        logic [2:0]  kind;
        logic [1:0]  status;
        logic [63:0] raw;
    } job_t;

endpackage

`default_nettype wire

### rtl/mid_in_if.sv
// input byte channel of the decoder
`default_nettype none

interface mid_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] stream_byte;

    modport source (output valid, output stream_byte, input ready);
    modport sink (input valid, input stream_byte, output ready);
endinterface

`default_nettype wire

### rtl/mid_out_if.sv
// result channel of the decoder
`default_nettype none

interface mid_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] decoded_value;
    logic [1:0]  status;

    modport source (output valid, output decoded_value, output status, input ready);
    modport sink (input valid, input decoded_value, input status, output ready);
endinterface

`default_nettype wire

### rtl/mid_front.sv
// tag parser and payload shifter of the decoder
`default_nettype none
`include "assert_macros.svh"

module mid_front (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic [2:0]   mode,
    mid_in_if.sink            in_ch,
    input  wire logic         q_full,
    output logic              push,
    output mid_pkg::job_t     job
);

    logic        in_payload_reg, in_payload_next;
    logic [3:0]  bytes_left_reg, bytes_left_next;
    logic [2:0]  kind_reg, kind_next;
    logic [63:0] acc_reg, acc_next;

    logic        accept;
    logic [7:0]  b;
    logic        wide;
    logic        unsigned_mode;
    logic        start;
    logic [2:0]  start_kind;
    logic        bad_wide;

    assign in_ch.ready   = !q_full;
    assign accept        = in_ch.valid && in_ch.ready;
    assign b             = in_ch.stream_byte;
    assign wide          = (mode == mid_pkg::MODE_S64) || (mode == mid_pkg::MODE_U64);
    assign unsigned_mode = (mode == mid_pkg::MODE_U32) || (mode == mid_pkg::MODE_U64);

    // multi-byte tag decode
    always_comb
    begin
        start      = 1'b1;
        start_kind = mid_pkg::KIND_U8;
        bad_wide   = 1'b0;
        unique case (b)
            mid_pkg::TAG_UINT8:  start_kind = mid_pkg::KIND_U8;
            mid_pkg::TAG_UINT16: start_kind = mid_pkg::KIND_U16;
            mid_pkg::TAG_UINT32: start_kind = mid_pkg::KIND_U32;
            mid_pkg::TAG_UINT64:
            begin
                start_kind = mid_pkg::KIND_U64;
                bad_wide   = !wide;
            end
            mid_pkg::TAG_INT8:   start_kind = mid_pkg::KIND_S8;
            mid_pkg::TAG_INT16:  start_kind = mid_pkg::KIND_S16;
            mid_pkg::TAG_INT32:  start_kind = mid_pkg::KIND_S32;
            mid_pkg::TAG_INT64:
            begin
                start_kind = mid_pkg::KIND_S64;
                bad_wide   = !wide;
            end
            default:             start = 1'b0;
        endcase
    end

    always_comb
    begin
        in_payload_next = in_payload_reg;
        bytes_left_next = bytes_left_reg;
        kind_next       = kind_reg;
        acc_next        = acc_reg;
        push            = 1'b0;
        job.is_finish   = 1'b0;
        job.kind        = mid_pkg::KIND_U8;
        job.status      = mid_pkg::STATUS_OK;
        job.raw         = '0;
        if (accept)
        begin
            if (in_payload_reg)
            begin
                acc_next = {acc_reg[55:0], b};
                if (bytes_left_reg != 4'd0)
                begin
                    bytes_left_next = bytes_left_reg - 4'd1;
                end
                if (bytes_left_next == 4'd0)
                begin
                    in_payload_next = 1'b0;
                    push            = 1'b1;
                    job.is_finish   = 1'b1;
                    job.kind        = kind_reg;
                    job.raw         = acc_next;
                end
            end
            else if (mode == mid_pkg::MODE_BOOL)
            begin
                push = 1'b1;
                if (b == mid_pkg::TAG_FALSE)
                begin
                    job.raw = 64'd0;
                end
                else if (b == mid_pkg::TAG_TRUE)
                begin
                    job.raw = 64'd1;
                end
                else
                begin
                    job.status = mid_pkg::STATUS_BAD_TAG;
                end
            end
            else if (mode > mid_pkg::MODE_BOOL)
            begin
                push       = 1'b1;
                job.status = mid_pkg::STATUS_BAD_TAG;
            end
            else if (b <= mid_pkg::TAG_POS_FIX_MAX)
            begin
                push          = 1'b1;
                job.is_finish = 1'b1;
                job.kind      = mid_pkg::KIND_U8;
                job.raw       = {56'd0, b};
            end
            else if (b >= mid_pkg::TAG_NEG_FIX_MIN)
            begin
                push = 1'b1;
                if (unsigned_mode)
                begin
                    job.status = mid_pkg::STATUS_BAD_TAG;
                end
                else
                begin
                    job.is_finish = 1'b1;
                    job.kind      = mid_pkg::KIND_S8;
                    job.raw       = {56'd0, b};
                end
            end
            else if (!start || bad_wide)
            begin
                push       = 1'b1;
                job.status = mid_pkg::STATUS_BAD_TAG;
            end
            else
            begin
                in_payload_next = 1'b1;
                kind_next       = start_kind;
                bytes_left_next = 4'd1 << start_kind[1:0];
                acc_next        = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_payload_reg <= 1'b0;
            bytes_left_reg <= 4'd0;
            kind_reg       <= mid_pkg::KIND_U8;
            acc_reg        <= '0;
        end
        else
        begin
            in_payload_reg <= in_payload_next;
            bytes_left_reg <= bytes_left_next;
            kind_reg       <= kind_next;
            acc_reg        <= acc_next;
        end
    end

    `MID_ASSERT(a_payload_count, clk, rst_n, in_payload_reg |-> ((bytes_left_reg != 4'd0) && (bytes_left_reg <= 4'd8)), "payload pending with bad byte count")
    `MID_ASSERT(a_push_accept, clk, rst_n, push |-> (accept && !q_full), "word pushed without an accepted byte")

endmodule

`default_nettype wire

### rtl/mid_queue.sv
// short job queue between parser and range checker
`default_nettype none
`include "assert_macros.svh"

module mid_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire mid_pkg::job_t push_job,
    output logic               full,
    input  wire logic          pop,
    output logic               head_valid,
    output mid_pkg::job_t      head_job
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    mid_pkg::job_t mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign full       = (count_reg == CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    `MID_ASSERT(a_count_bound, clk, rst_n, count_reg <= CW'(DEPTH), "queue count above depth")
    `MID_ASSERT_NEXT(a_count_up, clk, rst_n, do_push && !do_pop, count_reg == $past(count_reg) + CW'(1), "queue count missed a push")

endmodule

`default_nettype wire

### rtl/mid_back.sv
// extension, range check and output register of the decoder
`default_nettype none
`include "assert_macros.svh"

module mid_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic [2:0]    mode,
    input  wire logic          head_valid,
    input  wire mid_pkg::job_t head_job,
    output logic               pop,
    mid_out_if.source          out_ch
);

    logic        out_valid_reg, out_valid_next;
    logic [63:0] value_reg, value_next;
    logic [1:0]  status_reg, status_next;

    logic        is_signed;
    logic [63:0] ext;
    logic        neg;
    logic        ok;

    assign pop       = head_valid && (!out_valid_reg || out_ch.ready);
    assign is_signed = head_job.kind[2];

    always_comb
    begin
        unique case (head_job.kind[1:0])
            mid_pkg::SIZE_1: ext = is_signed ? {{56{head_job.raw[7]}}, head_job.raw[7:0]}
                                             : {56'd0, head_job.raw[7:0]};
            mid_pkg::SIZE_2: ext = is_signed ? {{48{head_job.raw[15]}}, head_job.raw[15:0]}
                                             : {48'd0, head_job.raw[15:0]};
            mid_pkg::SIZE_4: ext = is_signed ? {{32{head_job.raw[31]}}, head_job.raw[31:0]}
                                             : {32'd0, head_job.raw[31:0]};
            default:         ext = head_job.raw;
        endcase
    end

    assign neg = is_signed && ext[63];

    always_comb
    begin
        unique case (mode)
            mid_pkg::MODE_S32: ok = neg ? (ext[63:31] == {33{1'b1}}) : (ext[63:31] == 33'd0);
            mid_pkg::MODE_U32: ok = !neg && (ext[63:32] == 32'd0);
            mid_pkg::MODE_S64: ok = is_signed || !ext[63];
            mid_pkg::MODE_U64: ok = !neg;
            default:           ok = 1'b0;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        value_next     = value_reg;
        status_next    = status_reg;
        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (pop)
        begin
            out_valid_next = 1'b1;
            if (head_job.is_finish)
            begin
                value_next  = ok ? ext : 64'd0;
                status_next = ok ? mid_pkg::STATUS_OK : mid_pkg::STATUS_RANGE;
            end
            else
            begin
                value_next  = head_job.raw;
                status_next = head_job.status;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg  <= value_next;
        status_reg <= status_next;
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.decoded_value = value_reg;
    assign out_ch.status        = status_reg;

    `MID_ASSERT(a_error_zero, clk, rst_n, (out_valid_reg && (status_reg != mid_pkg::STATUS_OK)) |-> (value_reg == 64'd0), "error word carries a nonzero value")

endmodule

`default_nettype wire

### rtl/msgpack_integer_decoder_top.sv
// top level of the messagepack integer decoder
// takes one stream byte per cycle when the result side keeps up
// a result is registered in the job queue and then in the output register after its last byte is accepted
// fixints, booleans and bad tags complete on the tag byte, sized tags on their last payload byte
// a full job queue of QUEUE_DEPTH words stalls the input side
// reset: mode signed64, parser awaits a tag, queue and output register empty
`default_nettype none

module msgpack_integer_decoder_top #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        target_mode_we,
    input  wire logic [2:0]  target_mode,
    mid_in_if.sink           in_ch,
    mid_out_if.source        out_ch
);

    logic [2:0]    mode_reg, mode_next;
    logic          q_full;
    logic          push;
    mid_pkg::job_t push_job;
    logic          pop;
    logic          head_valid;
    mid_pkg::job_t head_job;

    assign mode_next = target_mode_we ? target_mode : mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= mid_pkg::MODE_S64;
        end
        else
        begin
            mode_reg <= mode_next;
        end
    end

    mid_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .mode   (mode_reg),
        .in_ch  (in_ch),
        .q_full (q_full),
        .push   (push),
        .job    (push_job)
    );

    mid_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    mid_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .mode       (mode_reg),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .out_ch     (out_ch)
    );

endmodule

`default_nettype wire
